[rtl/bpeq_pkg.sv]
// shared types, codes and constants for the button press event qualifier
`default_nettype none

package bpeq_pkg;

  // time arithmetic width, all timestamps wrap at this width
  localparam int TIME_BITS = 32;
  localparam int NBTN      = 4;

  // button positions
  localparam int BTN_START  = 0;
  localparam int BTN_STOP   = 1;
  localparam int BTN_SELECT = 2;
  localparam int BTN_GAP    = 3;

  // word operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // configuration register indexes
  localparam logic CFG_DEBOUNCE   = 1'b0;
  localparam logic CFG_LONG_PRESS = 1'b1;

  // reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

  // event codes
  localparam logic [3:0] EV_NONE         = 4'd0;
  localparam logic [3:0] EV_COMBO        = 4'd1;
  localparam logic [3:0] EV_START_LONG   = 4'd2;
  localparam logic [3:0] EV_START_SHORT  = 4'd3;
  localparam logic [3:0] EV_STOP_LONG    = 4'd4;
  localparam logic [3:0] EV_STOP_SHORT   = 4'd5;
  localparam logic [3:0] EV_SELECT_LONG  = 4'd6;
  localparam logic [3:0] EV_SELECT_SHORT = 4'd7;
  localparam logic [3:0] EV_GAP          = 4'd8;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic        raw_start;
    logic        raw_stop;
    logic        raw_select;
    logic        raw_gap;
  } in_word_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic [3:0] held_mask;
  } out_word_t;

  // per-button status towards the combo and event logic
  typedef struct packed {
    logic held_nxt;
    logic long_fire;
    logic short_fire;
  } btn_stat_t;

  // combo status towards the event logic
  typedef struct packed {
    logic fire;
    logic release_clear;
  } combo_stat_t;

  // reduce a millisecond stamp to the time width
  function automatic time_t to_time(input logic [31:0] v);
    logic [63:0] w;
    w = {32'd0, v};
    return w[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/button_press_event_qualifier_core.sv]
// top level of the button press event qualifier
//
// Debounces four active-low buttons (start, stop, select, gap) from sample
// words carrying a wrapping millisecond stamp, flags short and long presses
// and the start plus stop combo, and hands back the highest-priority pending
// event on a read word. Every word gives exactly one result word with the
// event code (none on samples) and the debounced held mask. One word is
// taken per clock cycle while the result register is not held by out_stall:
// the word is registered, the whole state update is done combinationally
// between that register and the result register, and the next word uses the
// updated state straight away. The user is to write configuration through
// the cfg port while no word is in flight; the block does not enforce it.
`default_nettype none

module button_press_event_qualifier_core
  import bpeq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic                 s1_v_r;
  in_word_t             s1_word_r;
  logic                 out_v_r;
  out_word_t            out_word_r;
  logic [15:0]          debounce_r;
  logic [15:0]          long_press_r;
  logic                 adv;
  logic                 smp;
  logic                 rd;
  time_t                now;
  logic [NBTN-1:0]      level;
  logic [NBTN-1:0]      force_ld;
  logic [NBTN-1:0]      held_mask;
  btn_stat_t [NBTN-1:0] bstat;
  combo_stat_t          cstat;
  logic [3:0]           event_code;

  // pipeline control: process the input register when the result slot frees
  assign adv       = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !adv;
  assign smp       = adv && (s1_word_r.op == OP_SAMPLE);
  assign rd        = adv && (s1_word_r.op == OP_READ);
  assign now       = to_time(s1_word_r.now_ms);
  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

  assign level[BTN_START]  = s1_word_r.raw_start;
  assign level[BTN_STOP]   = s1_word_r.raw_stop;
  assign level[BTN_SELECT] = s1_word_r.raw_select;
  assign level[BTN_GAP]    = s1_word_r.raw_gap;

  // a fired combo marks both start and stop long presses as done
  always_comb begin
    force_ld            = '0;
    force_ld[BTN_START] = cstat.fire;
    force_ld[BTN_STOP]  = cstat.fire;
  end

  // per-button qualifiers
  for (genvar g = 0; g < NBTN; g++) begin : g_btn
    bpeq_button u_btn (
      .clk             (clk),
      .rst_n           (rst_n),
      .en              (smp),
      .level           (level[g]),
      .now             (now),
      .debounce_time   (debounce_r),
      .long_press_time (long_press_r),
      .force_long_done (force_ld[g]),
      .stat            (bstat[g])
    );
    assign held_mask[g] = bstat[g].held_nxt;
  end

  // combo detector
  bpeq_combo u_combo (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (smp),
    .start_held      (bstat[BTN_START].held_nxt),
    .stop_held       (bstat[BTN_STOP].held_nxt),
    .now             (now),
    .long_press_time (long_press_r),
    .stat            (cstat)
  );

  // pending events and read-out
  bpeq_events u_events (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd         (rd),
    .bstat      (bstat),
    .cstat      (cstat),
    .event_code (event_code)
  );

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_word;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r.event_code <= event_code;
      out_word_r.held_mask  <= held_mask;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        CFG_LONG_PRESS: long_press_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/bpeq_button.sv]
// debounce and press qualification for one button
`default_nettype none

module bpeq_button
  import bpeq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        level,
  input  wire time_t       now,
  input  wire logic [15:0] debounce_time,
  input  wire logic [15:0] long_press_time,
  input  wire logic        force_long_done,
  output btn_stat_t        stat
);

  logic  last_level_r, last_level_nxt;
  logic  stable_r, stable_nxt;
  logic  held_r, held_nxt;
  logic  long_done_r, long_done_nxt;
  time_t last_change_r, last_change_nxt;
  time_t press_start_r, press_start_nxt;
  logic  long_fire, short_fire;
  time_t since_change, since_press;

  // a raw change restarts the debounce timer on this very sample
  assign since_change = (level != last_level_r) ? time_t'(0) : now - last_change_r;
  assign since_press  = now - press_start_r;

  // debounce and press state update for one sample
  always_comb begin
    last_level_nxt  = last_level_r;
    stable_nxt      = stable_r;
    held_nxt        = held_r;
    long_done_nxt   = long_done_r;
    last_change_nxt = last_change_r;
    press_start_nxt = press_start_r;
    long_fire       = 1'b0;
    short_fire      = 1'b0;
    if (en) begin
      if (level != last_level_r) begin
        last_change_nxt = now;
        last_level_nxt  = level;
      end
      if (since_change >= time_t'(debounce_time)) begin
        if (level == stable_r) begin
          if (!level && held_r && !long_done_r &&
              since_press >= time_t'(long_press_time)) begin
            long_done_nxt = 1'b1;
            long_fire     = 1'b1;
          end
        end else begin
          stable_nxt = level;
          if (!level && !held_r) begin
            held_nxt        = 1'b1;
            press_start_nxt = now;
            long_done_nxt   = 1'b0;
          end else if (level && held_r) begin
            held_nxt = 1'b0;
            if (!long_done_r) begin
              short_fire = 1'b1;
            end
          end
        end
      end
    end
  end

  assign stat.held_nxt   = held_nxt;
  assign stat.long_fire  = long_fire;
  assign stat.short_fire = short_fire;

  // button state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b1;
      stable_r      <= 1'b1;
      held_r        <= 1'b0;
      long_done_r   <= 1'b0;
      last_change_r <= '0;
      press_start_r <= '0;
    end else begin
      last_level_r  <= last_level_nxt;
      stable_r      <= stable_nxt;
      held_r        <= held_nxt;
      long_done_r   <= long_done_nxt | force_long_done;
      last_change_r <= last_change_nxt;
      press_start_r <= press_start_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bpeq_combo.sv]
// start plus stop combo detection
`default_nettype none

module bpeq_combo
  import bpeq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        start_held,
  input  wire logic        stop_held,
  input  wire time_t       now,
  input  wire logic [15:0] long_press_time,
  output combo_stat_t      stat
);

  logic  active_r, active_nxt;
  logic  done_r, done_nxt;
  time_t start_r, start_nxt;
  logic  both;
  time_t since_start;

  assign both        = start_held & stop_held;
  assign since_start = now - start_r;

  // combo state update for one sample
  always_comb begin
    active_nxt         = active_r;
    done_nxt           = done_r;
    start_nxt          = start_r;
    stat.fire          = 1'b0;
    stat.release_clear = 1'b0;
    if (en) begin
      if (both && !active_r) begin
        active_nxt = 1'b1;
        start_nxt  = now;
        done_nxt   = 1'b0;
      end else if (both && !done_r) begin
        if (since_start >= time_t'(long_press_time)) begin
          done_nxt  = 1'b1;
          stat.fire = 1'b1;
        end
      end else if (!both) begin
        if (active_r && done_r) begin
          stat.release_clear = 1'b1;
        end
        active_nxt = 1'b0;
      end
    end
  end

  // combo registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      start_r  <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bpeq_events.sv]
// pending event flags and priority read-out
`default_nettype none

module bpeq_events
  import bpeq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   rd,
  input  wire btn_stat_t [NBTN-1:0]   bstat,
  input  wire combo_stat_t            cstat,
  output logic [3:0]                  event_code
);

  logic [NBTN-1:0] long_r, long_nxt;
  logic [NBTN-1:0] short_r, short_nxt;
  logic            combo_r, combo_nxt;

  // flag setting from samples, priority pick and clear on reads
  always_comb begin
    long_nxt   = long_r;
    short_nxt  = short_r;
    combo_nxt  = combo_r;
    event_code = EV_NONE;
    for (int i = 0; i < NBTN; i++) begin
      if (bstat[i].long_fire)  long_nxt[i]  = 1'b1;
      if (bstat[i].short_fire) short_nxt[i] = 1'b1;
    end
    if (cstat.fire) begin
      combo_nxt           = 1'b1;
      long_nxt[BTN_START] = 1'b0;
      long_nxt[BTN_STOP]  = 1'b0;
    end
    if (cstat.release_clear) begin
      short_nxt[BTN_START] = 1'b0;
      short_nxt[BTN_STOP]  = 1'b0;
    end
    if (rd) begin
      if (combo_r) begin
        combo_nxt  = 1'b0;
        event_code = EV_COMBO;
      end else if (long_r[BTN_START]) begin
        long_nxt[BTN_START] = 1'b0;
        event_code          = EV_START_LONG;
      end else if (short_r[BTN_START]) begin
        short_nxt[BTN_START] = 1'b0;
        event_code           = EV_START_SHORT;
      end else if (long_r[BTN_STOP]) begin
        long_nxt[BTN_STOP] = 1'b0;
        event_code         = EV_STOP_LONG;
      end else if (short_r[BTN_STOP]) begin
        short_nxt[BTN_STOP] = 1'b0;
        event_code          = EV_STOP_SHORT;
      end else if (long_r[BTN_SELECT]) begin
        long_nxt[BTN_SELECT] = 1'b0;
        event_code           = EV_SELECT_LONG;
      end else if (short_r[BTN_SELECT]) begin
        short_nxt[BTN_SELECT] = 1'b0;
        event_code            = EV_SELECT_SHORT;
      end else if (short_r[BTN_GAP]) begin
        short_nxt[BTN_GAP] = 1'b0;
        event_code         = EV_GAP;
      end
    end
  end

  // pending flag registers; the gap long flag is kept but never reported
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r  <= '0;
      short_r <= '0;
      combo_r <= 1'b0;
    end else begin
      long_r  <= long_nxt;
      short_r <= short_nxt;
      combo_r <= combo_nxt;
    end
  end

endmodule

`default_nettype wire

[test/bpeq_event_checker.sv]
// checker for the button press event qualifier: predicts each result word and compares it
`default_nettype none

module bpeq_event_checker
  import bpeq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_word_t    in_word,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_word_t   out_word,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               words_waiting,
  output int               events_seen
);

  // configuration as seen on the cfg port
  logic [15:0] debounce_ms;
  logic [15:0] long_ms;

  // per-button debounce and press tracking
  logic [NBTN-1:0] lvl_last;
  logic [NBTN-1:0] lvl_stable;
  logic [NBTN-1:0] btn_held;
  logic [NBTN-1:0] long_fired;
  logic [NBTN-1:0] short_flag;
  logic [NBTN-1:0] long_flag;
  time_t           change_at [NBTN];
  time_t           press_at  [NBTN];

  // start plus stop combo tracking
  logic  combo_on;
  logic  combo_fired;
  logic  combo_flag;
  time_t combo_at;

  // results predicted but not yet seen
  out_word_t predicted_words [$];

  function automatic void clear_state();
    debounce_ms = DEBOUNCE_RST;
    long_ms     = LONG_PRESS_RST;
    lvl_last    = '1;
    lvl_stable  = '1;
    btn_held    = '0;
    long_fired  = '0;
    short_flag  = '0;
    long_flag   = '0;
    for (int b = 0; b < NBTN; b++) begin
      change_at[b] = '0;
      press_at[b]  = '0;
    end
    combo_on    = 1'b0;
    combo_fired = 1'b0;
    combo_flag  = 1'b0;
    combo_at    = '0;
  endfunction

  // wrapping difference of two stamps
  function automatic time_t elapsed_ms(input time_t now, input time_t then);
    time_t d;
    d = now - then;
    return d;
  endfunction

  // debounce one button and track its short and long press
  function automatic void debounce_button(input int b, input logic lvl, input time_t now);
    if (lvl != lvl_last[b]) begin
      change_at[b] = now;
      lvl_last[b]  = lvl;
    end
    if (elapsed_ms(now, change_at[b]) < time_t'(debounce_ms))
      return;
    if (lvl == lvl_stable[b]) begin
      // level already accepted: only a held press can turn long
      if (!lvl && btn_held[b] && !long_fired[b] &&
          elapsed_ms(now, press_at[b]) >= time_t'(long_ms)) begin
        long_fired[b] = 1'b1;
        long_flag[b]  = 1'b1;
      end
      return;
    end
    lvl_stable[b] = lvl;
    if (!lvl && !btn_held[b]) begin
      btn_held[b]   = 1'b1;
      press_at[b]   = now;
      long_fired[b] = 1'b0;
    end else if (lvl && btn_held[b]) begin
      btn_held[b] = 1'b0;
      if (!long_fired[b])
        short_flag[b] = 1'b1;
    end
  endfunction

  // combo fires once both start and stop stay held for the long time
  function automatic void update_combo(input time_t now);
    logic both;
    both = btn_held[BTN_START] && btn_held[BTN_STOP];
    if (both && !combo_on) begin
      combo_on    = 1'b1;
      combo_at    = now;
      combo_fired = 1'b0;
    end else if (both && !combo_fired) begin
      if (elapsed_ms(now, combo_at) >= time_t'(long_ms)) begin
        combo_fired           = 1'b1;
        combo_flag            = 1'b1;
        long_fired[BTN_START] = 1'b1;
        long_flag[BTN_START]  = 1'b0;
        long_fired[BTN_STOP]  = 1'b1;
        long_flag[BTN_STOP]   = 1'b0;
      end
    end else if (!both) begin
      // releasing a fired combo drops both short presses
      if (combo_on && combo_fired) begin
        short_flag[BTN_START] = 1'b0;
        short_flag[BTN_STOP]  = 1'b0;
      end
      combo_on = 1'b0;
    end
  endfunction

  // hand out the highest-priority pending event and clear it
  function automatic logic [3:0] take_event();
    if (combo_flag) begin
      combo_flag = 1'b0;
      return EV_COMBO;
    end
    if (long_flag[BTN_START]) begin
      long_flag[BTN_START] = 1'b0;
      return EV_START_LONG;
    end
    if (short_flag[BTN_START]) begin
      short_flag[BTN_START] = 1'b0;
      return EV_START_SHORT;
    end
    if (long_flag[BTN_STOP]) begin
      long_flag[BTN_STOP] = 1'b0;
      return EV_STOP_LONG;
    end
    if (short_flag[BTN_STOP]) begin
      short_flag[BTN_STOP] = 1'b0;
      return EV_STOP_SHORT;
    end
    if (long_flag[BTN_SELECT]) begin
      long_flag[BTN_SELECT] = 1'b0;
      return EV_SELECT_LONG;
    end
    if (short_flag[BTN_SELECT]) begin
      short_flag[BTN_SELECT] = 1'b0;
      return EV_SELECT_SHORT;
    end
    // gap long press stays pending for good
    if (short_flag[BTN_GAP]) begin
      short_flag[BTN_GAP] = 1'b0;
      return EV_GAP;
    end
    return EV_NONE;
  endfunction

  // expected result word for one accepted word
  function automatic out_word_t qualify_word(input in_word_t w);
    out_word_t r;
    time_t     now;
    r.event_code = EV_NONE;
    if (w.op == OP_SAMPLE) begin
      now = time_t'(w.now_ms);
      debounce_button(BTN_START,  w.raw_start,  now);
      debounce_button(BTN_STOP,   w.raw_stop,   now);
      debounce_button(BTN_SELECT, w.raw_select, now);
      debounce_button(BTN_GAP,    w.raw_gap,    now);
      update_combo(now);
    end else begin
      r.event_code = take_event();
    end
    r.held_mask = btn_held;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // watch the ports, compare results, then predict the newly accepted word
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      clear_state();
      predicted_words.delete();
      fail_count    = 0;
      events_seen   = 0;
      words_waiting <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEBOUNCE)
          debounce_ms = cfg_data;
        else
          long_ms = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (predicted_words.size() == 0) begin
          flag_mismatch($sformatf("result word %h with nothing expected", out_word));
        end else begin
          want = predicted_words.pop_front();
          if (out_word.event_code !== want.event_code)
            flag_mismatch($sformatf("event code %0d, expected %0d",
                                    out_word.event_code, want.event_code));
          if (out_word.held_mask !== want.held_mask)
            flag_mismatch($sformatf("held mask %b, expected %b",
                                    out_word.held_mask, want.held_mask));
          if (want.event_code != EV_NONE)
            events_seen++;
        end
      end
      if (in_valid && !in_stall)
        predicted_words.push_back(qualify_word(in_word));
      words_waiting <= predicted_words.size();
    end
  end

endmodule

`default_nettype wire

[test/tb_button_press_event_qualifier_core.sv]
// testbench top for the button press event qualifier: stimulus, receiver stalls and verdict
`default_nettype none

module tb_button_press_event_qualifier_core
  import bpeq_pkg::*;
();

  localparam int HOLD_CYCLES = 64;

  // pressed masks, one bit per button
  localparam logic [3:0] PR_NONE   = 4'b0000;
  localparam logic [3:0] PR_START  = 4'b0001 << BTN_START;
  localparam logic [3:0] PR_STOP   = 4'b0001 << BTN_STOP;
  localparam logic [3:0] PR_SELECT = 4'b0001 << BTN_SELECT;
  localparam logic [3:0] PR_GAP    = 4'b0001 << BTN_GAP;
  localparam logic [3:0] PR_ALL    = PR_START | PR_STOP | PR_SELECT | PR_GAP;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int words_waiting;
  int events_seen;

  int samples_sent   = 0;
  int reads_sent     = 0;
  int settings_used  = 1;
  int burst_left     = 1;
  bit gaps_on        = 1'b1;
  int holds_asked    = 0;
  int holds_served   = 0;

  button_press_event_qualifier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bpeq_event_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_waiting (words_waiting),
    .events_seen   (events_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: stall segments of varying density, plus long hold-offs on request
  initial begin
    int stall_pct;
    int seg_len;
    out_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
      seg_len = $urandom_range(10, 80);
      repeat (seg_len) begin
        if (holds_served != holds_asked) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          holds_served++;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  function automatic in_word_t tick_word(input logic [31:0] t, input logic [3:0] pressed);
    in_word_t w;
    w.op         = OP_SAMPLE;
    w.now_ms     = t;
    w.raw_start  = ~pressed[BTN_START];
    w.raw_stop   = ~pressed[BTN_STOP];
    w.raw_select = ~pressed[BTN_SELECT];
    w.raw_gap    = ~pressed[BTN_GAP];
    return w;
  endfunction

  // read words carry random junk in the fields the block ignores
  function automatic in_word_t read_word();
    in_word_t w;
    w.op         = OP_READ;
    w.now_ms     = $urandom;
    w.raw_start  = 1'($urandom_range(0, 1));
    w.raw_stop   = 1'($urandom_range(0, 1));
    w.raw_select = 1'($urandom_range(0, 1));
    w.raw_gap    = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // button sets to hold, leaning on start plus stop for the combo
  function automatic logic [3:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20)
      return PR_NONE;
    if (r < 50)
      return PR_START | PR_STOP | (4'($urandom_range(0, 15)) & (PR_SELECT | PR_GAP));
    return 4'($urandom_range(0, 15));
  endfunction

  // offer one word, then idle between bursts when gaps are on
  task automatic offer(input in_word_t w);
    int gap;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (w.op == OP_SAMPLE)
      samples_sent++;
    else
      reads_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] db, input logic [15:0] lp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= db;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= lp;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random presses held for a while, with bounces, time jumps and reads mixed in
  task automatic run_phase(input logic [15:0] db, input logic [15:0] lp, input int n_items,
                           input bit idle_gaps, input bit with_hold);
    logic [3:0]  target;
    logic [3:0]  levels;
    logic [31:0] clock_ms;
    logic [31:0] step_max;
    int          hold_ticks;
    int          r;
    settle();
    set_regs(db, lp);
    settings_used++;
    gaps_on    = idle_gaps;
    step_max   = (32'(db) + 32'(lp)) / 3 + 1;
    clock_ms   = $urandom;
    target     = PR_NONE;
    hold_ticks = 0;
    for (int k = 0; k < n_items; k++) begin
      if (with_hold && k == n_items / 2)
        holds_asked <= holds_asked + 1;
      if ($urandom_range(0, 99) < 20) begin
        offer(read_word());
      end else begin
        if (hold_ticks == 0) begin
          target     = pick_target();
          hold_ticks = $urandom_range(1, 20);
        end
        hold_ticks--;
        levels = target;
        if ($urandom_range(0, 15) == 0)
          levels = levels ^ (4'b0001 << $urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 3)
          clock_ms = $urandom;
        else if (r >= 8)
          clock_ms = clock_ms + $urandom_range(0, step_max);
        offer(tick_word(clock_ms, levels));
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read with nothing pending, then a fired combo and its release
    offer(read_word());
    offer(tick_word(32'd0,    PR_NONE));
    offer(tick_word(32'd10,   PR_START | PR_STOP));
    offer(tick_word(32'd60,   PR_START | PR_STOP));
    offer(tick_word(32'd1060, PR_START | PR_STOP));
    offer(tick_word(32'd1100, PR_NONE));
    offer(tick_word(32'd1150, PR_NONE));
    offer(read_word());
    offer(read_word());

    // press across the stamp wrap, long select and gap, short start and stop
    offer(tick_word(32'hFFFF_FFFF, PR_SELECT | PR_GAP));
    offer(tick_word(32'h0000_0031, PR_SELECT | PR_GAP));
    offer(tick_word(32'h0000_0419, PR_SELECT | PR_GAP));
    offer(tick_word(32'h0000_0420, PR_ALL));
    offer(tick_word(32'h0000_0452, PR_ALL));
    offer(tick_word(32'h0000_0460, PR_NONE));
    offer(tick_word(32'h0000_04A0, PR_NONE));
    repeat (4) offer(read_word());

    // zero debounce and long times act on the same tick
    settle();
    set_regs(16'd0, 16'd0);
    settings_used++;
    offer(tick_word(32'd7,  PR_GAP));
    offer(tick_word(32'd7,  PR_GAP));
    offer(tick_word(32'd8,  PR_NONE));
    offer(tick_word(32'd9,  PR_GAP));
    offer(tick_word(32'd10, PR_NONE));
    offer(read_word());

    run_phase(16'd50,   16'd1000,  200, 1'b1, 1'b0);
    run_phase(16'd0,    16'd0,     220, 1'b0, 1'b1);
    run_phase(16'hFFFF, 16'hFFFF,  200, 1'b1, 1'b0);
    run_phase(16'd1,    16'd6,     220, 1'b1, 1'b1);
    run_phase(16'd3,    16'd20,    220, 1'b0, 1'b0);
    run_phase(16'd10,   16'd2,     180, 1'b1, 1'b0);
    run_phase(16'($urandom_range(0, 5)), 16'($urandom_range(0, 40)), 250, 1'b1, 1'b1);
    run_phase(16'd2,    16'd12,    260, 1'b1, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d sample words and %0d reads over %0d register settings",
             samples_sent, reads_sent, settings_used);
    $display("%0d non-empty events compared along with every held mask", events_seen);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
